>>> rtl/pattern_event_matcher_macros.svh
// Assertion macros of the pattern event matcher back end.
`ifndef PATTERN_EVENT_MATCHER_MACROS_SVH
`define PATTERN_EVENT_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define PEM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pattern_event_matcher: check failed");
`define PEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pattern_event_matcher: sequence check failed");
`else
`define PEM_ASSERT(label, prop)
`define PEM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/pem_pkg.sv
// Shared types, widths and codes of the pattern event matcher.
package pem_pkg;

  localparam int SLOT_W     = 4;
  localparam int START_W    = 8;
  localparam int LEN_W      = 9;
  localparam int STEP_W     = 32;
  localparam int PLEN_W     = 9;
  localparam int CNT_W      = 5;
  localparam int WSTEP_W    = 8;
  localparam int END_W      = 10;
  localparam int BIT_CNT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int DEF_MAX_EVENTS = 16;
  localparam int DEF_MAX_STEPS  = 256;

  localparam logic [PLEN_W-1:0] PLEN_RESET = 9'd16;
  localparam logic [CNT_W-1:0]  CNT_RESET  = 5'd0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_IN_USE  = 2'd1;

  // Slots reachable by the 4-bit slot field.
  localparam int SLOT_LIMIT = 2 ** SLOT_W;

  function automatic int table_depth(input int max_events);
    return (max_events < SLOT_LIMIT) ? max_events : SLOT_LIMIT;
  endfunction

  typedef struct packed {
    logic                is_query;
    logic                wr_en;
    logic [SLOT_W-1:0]   slot;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    length;
    logic                neg;
    logic [STEP_W-1:0]   mag;
  } cmd_t;

  typedef struct packed {
    logic [PLEN_W-1:0] plen;
    logic [CNT_W-1:0]  count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_RESULT
  } back_state_e;

endpackage

>>> rtl/pem_front.sv
// Front end: input beat capture, classification and a two-beat command queue.
module pem_front #(
  parameter int MAX_EVENTS = pem_pkg::DEF_MAX_EVENTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [pem_pkg::SLOT_W-1:0]       entry_index_i,
  input  logic [pem_pkg::START_W-1:0]      event_start_i,
  input  logic [pem_pkg::LEN_W-1:0]        event_length_i,
  input  logic signed [pem_pkg::STEP_W-1:0] absolute_step_i,
  output logic                             q_valid_o,
  output pem_pkg::cmd_t                    q_cmd_o,
  input  logic                             q_pop_i
);

  localparam int DEPTH = pem_pkg::table_depth(MAX_EVENTS);

  pem_pkg::cmd_t               cmd_in;
  pem_pkg::cmd_t               fifo_q [2];
  logic                        wr_ptr_q, wr_ptr_d;
  logic                        rd_ptr_q, rd_ptr_d;
  logic [1:0]                  cnt_q, cnt_d;
  logic                        push;
  logic [pem_pkg::STEP_W-1:0]  step_raw;

  // Classify the beat and split the step into sign and magnitude.
  always_comb begin
    step_raw         = absolute_step_i;
    cmd_in.is_query  = (op_i == pem_pkg::OP_QUERY);
    cmd_in.wr_en     = (op_i == pem_pkg::OP_WRITE) && (32'(entry_index_i) < 32'(DEPTH));
    cmd_in.slot      = entry_index_i;
    cmd_in.start     = event_start_i;
    cmd_in.length    = event_length_i;
    cmd_in.neg       = step_raw[pem_pkg::STEP_W-1];
    cmd_in.mag       = step_raw[pem_pkg::STEP_W-1] ? (~step_raw + 32'd1) : step_raw;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> rtl/pem_back.sv
// Back end: event table, serial step remainder, per-slot end remainders, result register.
`include "pattern_event_matcher_macros.svh"
module pem_back #(
  parameter int MAX_EVENTS = pem_pkg::DEF_MAX_EVENTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pem_pkg::cfg_t                 cfg_i,
  input  logic                          q_valid_i,
  input  pem_pkg::cmd_t                 q_cmd_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pem_pkg::WSTEP_W-1:0]   wrapped_step_o,
  output logic                          start_found_o,
  output logic [pem_pkg::SLOT_W-1:0]    start_slot_o,
  output logic                          active_found_o,
  output logic [pem_pkg::SLOT_W-1:0]    active_slot_o,
  output logic                          end_found_o
);

  localparam int DEPTH = pem_pkg::table_depth(MAX_EVENTS);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pem_pkg::back_state_e state_q, state_d;

  logic                           tbl_we, div_load, div_step, fix_en, out_load, out_free;
  logic                           is_query_q;
  logic                           neg_q;
  logic [pem_pkg::STEP_W-1:0]     mag_q;
  logic [pem_pkg::PLEN_W-1:0]     rem_q, rem_d;
  logic [pem_pkg::END_W-1:0]      rem_sh;
  logic [pem_pkg::BIT_CNT_W-1:0]  bit_cnt_q;
  logic [pem_pkg::PLEN_W-1:0]     step_q, step_d;
  logic                           lane_run;

  logic [pem_pkg::START_W-1:0]    start_q  [DEPTH];
  logic [pem_pkg::LEN_W-1:0]      len_q    [DEPTH];
  logic [pem_pkg::PLEN_W-1:0]     erem_q   [DEPTH];
  logic [pem_pkg::PLEN_W-1:0]     erem_d   [DEPTH];
  logic [pem_pkg::END_W-1:0]      lane_end [DEPTH];

  logic                           sf, af, ef;
  logic [pem_pkg::SLOT_W-1:0]     ss, as_slot;

  logic                           out_valid_q;
  logic [pem_pkg::WSTEP_W-1:0]    wstep_q;
  logic                           sf_q, af_q, ef_q;
  logic [pem_pkg::SLOT_W-1:0]     ss_q, as_q;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pem_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          state_d = q_cmd_i.is_query ? pem_pkg::ST_DIV : pem_pkg::ST_RESULT;
        end
      end
      pem_pkg::ST_DIV: begin
        if (bit_cnt_q == '0) begin
          state_d = pem_pkg::ST_FIX;
        end
      end
      pem_pkg::ST_FIX: begin
        state_d = pem_pkg::ST_RESULT;
      end
      pem_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = pem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pem_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    q_pop_o  = 1'b0;
    div_step = 1'b0;
    fix_en   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      pem_pkg::ST_IDLE:   q_pop_o  = q_valid_i;
      pem_pkg::ST_DIV:    div_step = 1'b1;
      pem_pkg::ST_FIX:    fix_en   = 1'b1;
      pem_pkg::ST_RESULT: out_load = out_free;
      default: ;
    endcase
  end

  assign tbl_we   = q_pop_o && q_cmd_i.wr_en;
  assign div_load = q_pop_o && q_cmd_i.is_query;

  // One restoring remainder step per cycle on the step magnitude.
  always_comb begin
    rem_sh = {rem_q, mag_q[pem_pkg::STEP_W-1]};
    if (rem_sh >= {1'b0, cfg_i.plen}) begin
      rem_d = pem_pkg::PLEN_W'(rem_sh - {1'b0, cfg_i.plen});
    end else begin
      rem_d = rem_sh[pem_pkg::PLEN_W-1:0];
    end
    step_d = (neg_q && (rem_q != '0)) ? (cfg_i.plen - rem_q) : rem_q;
  end

  // Per-slot end remainders step while the divider bit count is below END_W, MSB first.
  assign lane_run = (bit_cnt_q < pem_pkg::BIT_CNT_W'(pem_pkg::END_W));

  always_comb begin
    logic [pem_pkg::END_W-1:0] sh;
    for (int i = 0; i < DEPTH; i++) begin
      lane_end[i] = pem_pkg::END_W'(start_q[i]) + pem_pkg::END_W'(len_q[i]);
      sh          = {erem_q[i], lane_end[i][bit_cnt_q[3:0]]};
      if (sh >= {1'b0, cfg_i.plen}) begin
        erem_d[i] = pem_pkg::PLEN_W'(sh - {1'b0, cfg_i.plen});
      end else begin
        erem_d[i] = sh[pem_pkg::PLEN_W-1:0];
      end
    end
  end

  // Match across the enabled slots; lowest slot wins.
  always_comb begin
    logic en;
    sf      = 1'b0;
    af      = 1'b0;
    ef      = 1'b0;
    ss      = '0;
    as_slot = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      en = (32'(i) < 32'(cfg_i.count));
      if (en && ({1'b0, start_q[i]} == step_q)) begin
        sf = 1'b1;
        ss = pem_pkg::SLOT_W'(i);
      end
      if (en && ({1'b0, start_q[i]} <= step_q) && ({1'b0, step_q} < lane_end[i])) begin
        af      = 1'b1;
        as_slot = pem_pkg::SLOT_W'(i);
      end
      if (en && (len_q[i] < cfg_i.plen) && (erem_q[i] == step_q)) begin
        ef = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pem_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (div_load) begin
        bit_cnt_q <= pem_pkg::BIT_CNT_W'(pem_pkg::STEP_W - 1);
      end else if (div_step) begin
        bit_cnt_q <= bit_cnt_q - pem_pkg::BIT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      start_q[q_cmd_i.slot[IDX_W-1:0]] <= q_cmd_i.start;
      len_q[q_cmd_i.slot[IDX_W-1:0]]   <= q_cmd_i.length;
    end
    if (q_pop_o) begin
      is_query_q <= q_cmd_i.is_query;
    end
    if (div_load) begin
      neg_q <= q_cmd_i.neg;
      mag_q <= q_cmd_i.mag;
      rem_q <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        erem_q[i] <= '0;
      end
    end else if (div_step) begin
      mag_q <= {mag_q[pem_pkg::STEP_W-2:0], 1'b0};
      rem_q <= rem_d;
      if (lane_run) begin
        for (int i = 0; i < DEPTH; i++) begin
          erem_q[i] <= erem_d[i];
        end
      end
    end
    if (fix_en) begin
      step_q <= step_d;
    end
    if (out_load) begin
      wstep_q <= is_query_q ? step_q[pem_pkg::WSTEP_W-1:0] : '0;
      sf_q    <= is_query_q && sf;
      ss_q    <= is_query_q ? ss : '0;
      af_q    <= is_query_q && af;
      as_q    <= is_query_q ? as_slot : '0;
      ef_q    <= is_query_q && ef;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign wrapped_step_o = wstep_q;
  assign start_found_o  = sf_q;
  assign start_slot_o   = ss_q;
  assign active_found_o = af_q;
  assign active_slot_o  = as_q;
  assign end_found_o    = ef_q;

  // Slot zero only carries a defined end remainder once it takes part in matching.
  `PEM_ASSERT(a_rem_below_len, (state_q != pem_pkg::ST_DIV) || (rem_q < cfg_i.plen))
  `PEM_ASSERT(a_lane_rem_below_len, (state_q != pem_pkg::ST_DIV) || (cfg_i.count == '0) || (erem_q[0] < cfg_i.plen))
  `PEM_ASSERT_NEXT(a_div_ends_in_fix, (state_q == pem_pkg::ST_DIV) && (bit_cnt_q == '0), state_q == pem_pkg::ST_FIX)
  `PEM_ASSERT(a_no_result_overwrite, !out_load || !out_valid_q || !out_stall_i)
  `PEM_ASSERT(a_step_in_pattern, (state_q != pem_pkg::ST_RESULT) || !is_query_q || (step_q < cfg_i.plen))

endmodule

>>> rtl/pattern_event_matcher.sv
// Top level of the pattern event matcher: config registers, front queue and back end.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   op, entry_index, event_start,
//                                                  event_length, absolute_step
//   out       output     out_valid_o / out_stall_i wrapped_step, start/active found+slot,
//                                                  end_found
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A query goes from dispatch through the bit-serial remainder unit that wraps the 32-bit
// step, then a sign fix-up and the load of the result register; a write beat goes from
// dispatch straight to the result register.
// Reset clears control state and config registers; the event table is not cleared.
// A two-beat queue decouples input from the back end, and the result register holds
// a beat while out_stall_i is high.
module pattern_event_matcher #(
  parameter int MAX_EVENTS = pem_pkg::DEF_MAX_EVENTS,
  parameter int MAX_STEPS  = pem_pkg::DEF_MAX_STEPS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic [pem_pkg::SLOT_W-1:0]         entry_index_i,
  input  logic [pem_pkg::START_W-1:0]        event_start_i,
  input  logic [pem_pkg::LEN_W-1:0]          event_length_i,
  input  logic signed [pem_pkg::STEP_W-1:0]  absolute_step_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pem_pkg::WSTEP_W-1:0]        wrapped_step_o,
  output logic                               start_found_o,
  output logic [pem_pkg::SLOT_W-1:0]         start_slot_o,
  output logic                               active_found_o,
  output logic [pem_pkg::SLOT_W-1:0]         active_slot_o,
  output logic                               end_found_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pem_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pem_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [pem_pkg::PLEN_W-1:0] plen_q, plen_d;
  logic [pem_pkg::CNT_W-1:0]  count_q, count_d;
  pem_pkg::cfg_t              cfg_eff;
  logic                       q_valid;
  logic                       q_pop;
  pem_pkg::cmd_t              q_cmd;

  // The user must issue config writes only while idle; the block does not enforce it and accepts every beat.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    plen_d  = plen_q;
    count_d = count_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pem_pkg::CFG_PATTERN_LENGTH: plen_d  = cfg_data_i[pem_pkg::PLEN_W-1:0];
        pem_pkg::CFG_EVENTS_IN_USE:  count_d = cfg_data_i[pem_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= pem_pkg::PLEN_RESET;
      count_q <= pem_pkg::CNT_RESET;
    end else begin
      plen_q  <= plen_d;
      count_q <= count_d;
    end
  end

  // Effective settings: a zero pattern length acts as one step, and both values
  // saturate at the configured maxima.
  always_comb begin
    if (plen_q == '0) begin
      cfg_eff.plen = pem_pkg::PLEN_W'(1);
    end else if (32'(plen_q) > 32'(MAX_STEPS)) begin
      cfg_eff.plen = pem_pkg::PLEN_W'(MAX_STEPS);
    end else begin
      cfg_eff.plen = plen_q;
    end
    if (32'(count_q) > 32'(MAX_EVENTS)) begin
      cfg_eff.count = pem_pkg::CNT_W'(MAX_EVENTS);
    end else begin
      cfg_eff.count = count_q;
    end
  end

  pem_front #(
    .MAX_EVENTS(MAX_EVENTS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .entry_index_i  (entry_index_i),
    .event_start_i  (event_start_i),
    .event_length_i (event_length_i),
    .absolute_step_i(absolute_step_i),
    .q_valid_o      (q_valid),
    .q_cmd_o        (q_cmd),
    .q_pop_i        (q_pop)
  );

  pem_back #(
    .MAX_EVENTS(MAX_EVENTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_eff),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .wrapped_step_o (wrapped_step_o),
    .start_found_o  (start_found_o),
    .start_slot_o   (start_slot_o),
    .active_found_o (active_found_o),
    .active_slot_o  (active_slot_o),
    .end_found_o    (end_found_o)
  );

endmodule

>>> dv/tb_pattern_event_matcher.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pattern event matcher: directed and random beats, scoreboard.
module tb_pattern_event_matcher;
  import pem_pkg::*;

  // One input beat as the sender sees it. Fields that the op does not use
  // still carry random values.
  typedef struct packed {
    logic               op;
    logic [SLOT_W-1:0]  slot;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   dur;
    logic [STEP_W-1:0]  step;
  } seq_item_t;

  // Predicted match result of one input beat.
  typedef struct packed {
    logic [WSTEP_W-1:0] wstep;
    logic               start_hit;
    logic [SLOT_W-1:0]  start_slot;
    logic               active_hit;
    logic [SLOT_W-1:0]  active_slot;
    logic               end_hit;
  } match_t;

  // Drive every input to a known value from time zero; hold reset from the start.
  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_stall_o;
  logic                      op_i            = OP_WRITE;
  logic [SLOT_W-1:0]         entry_index_i   = '0;
  logic [START_W-1:0]        event_start_i   = '0;
  logic [LEN_W-1:0]          event_length_i  = '0;
  logic signed [STEP_W-1:0]  absolute_step_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i     = 1'b0;
  logic [WSTEP_W-1:0]        wrapped_step_o;
  logic                      start_found_o;
  logic [SLOT_W-1:0]         start_slot_o;
  logic                      active_found_o;
  logic [SLOT_W-1:0]         active_slot_o;
  logic                      end_found_o;
  logic                      cfg_valid_i     = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i     = CFG_PATTERN_LENGTH;
  logic [CFG_DATA_W-1:0]     cfg_data_i      = '0;

  // Shadow copy of the event table and the two registers.
  logic [START_W-1:0] slot_start [DEF_MAX_EVENTS];
  logic [LEN_W-1:0]   slot_dur   [DEF_MAX_EVENTS];
  logic [PLEN_W-1:0]  loop_len_reg    = PLEN_RESET;
  logic [CNT_W-1:0]   live_events_reg = CNT_RESET;

  match_t predicted_matches [$];
  int     mismatches = 0;
  bit     no_idle    = 1'b0;

  always #4 clk_i = ~clk_i;

  pattern_event_matcher i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .entry_index_i   (entry_index_i),
    .event_start_i   (event_start_i),
    .event_length_i  (event_length_i),
    .absolute_step_i (absolute_step_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .wrapped_step_o  (wrapped_step_o),
    .start_found_o   (start_found_o),
    .start_slot_o    (start_slot_o),
    .active_found_o  (active_found_o),
    .active_slot_o   (active_slot_o),
    .end_found_o     (end_found_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Effective pattern length: zero acts as one, anything past the table saturates.
  function automatic int loop_steps();
    int p;
    p = int'(loop_len_reg);
    if (p == 0) p = 1;
    if (p > DEF_MAX_STEPS) p = DEF_MAX_STEPS;
    return p;
  endfunction

  function automatic int live_events();
    return (int'(live_events_reg) > DEF_MAX_EVENTS) ? DEF_MAX_EVENTS : int'(live_events_reg);
  endfunction

  // Apply one beat to the shadow table and work out the match result it produces.
  function automatic match_t match_step(input seq_item_t it);
    match_t m;
    int     p;
    int     n;
    int     st;
    int     fin;
    int     pos;
    longint r;
    m = '0;
    if (it.op == OP_WRITE) begin
      // A write only updates the slot; its result is all zero.
      slot_start[it.slot] = it.start;
      slot_dur[it.slot]   = it.dur;
    end else begin
      p = loop_steps();
      n = live_events();
      // Truncating remainder, then fold negatives back into the loop.
      r = longint'($signed(it.step)) % longint'(p);
      if (r < 0) r += p;
      pos = int'(r);
      for (int i = 0; i < n; i++) begin
        st  = int'(slot_start[i]);
        fin = st + int'(slot_dur[i]);
        if (!m.start_hit && st == pos) begin
          m.start_hit  = 1'b1;
          m.start_slot = SLOT_W'(i);
        end
        // Active span does not wrap around the loop end.
        if (!m.active_hit && pos >= st && pos < fin) begin
          m.active_hit  = 1'b1;
          m.active_slot = SLOT_W'(i);
        end
        // Only events shorter than the loop have an end; that end does wrap.
        if (int'(slot_dur[i]) < p && (fin % p) == pos) m.end_hit = 1'b1;
      end
      m.wstep = WSTEP_W'(pos);
    end
    return m;
  endfunction

  // Idle cycles before the next beat on either side; zero in burst stretches.
  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 4) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Present one beat after a random gap and hold it until the block takes it.
  task automatic send_item(input seq_item_t it);
    int gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= it.op;
    entry_index_i   <= it.slot;
    event_start_i   <= it.start;
    event_length_i  <= it.dur;
    absolute_step_i <= it.step;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted_matches.push_back(match_step(it));
  endtask

  task automatic send_write(input logic [SLOT_W-1:0] slot, input logic [START_W-1:0] start,
                            input logic [LEN_W-1:0] dur);
    seq_item_t it;
    it.op    = OP_WRITE;
    it.slot  = slot;
    it.start = start;
    it.dur   = dur;
    it.step  = $urandom();
    send_item(it);
  endtask

  task automatic send_query(input logic [STEP_W-1:0] step);
    seq_item_t it;
    it.op    = OP_QUERY;
    it.slot  = SLOT_W'($urandom());
    it.start = START_W'($urandom());
    it.dur   = LEN_W'($urandom());
    it.step  = step;
    send_item(it);
  endtask

  // Drop valid and hold off until every predicted result has been seen.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (predicted_matches.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == CFG_PATTERN_LENGTH) loop_len_reg = PLEN_W'(val);
    else if (idx == CFG_EVENTS_IN_USE) live_events_reg = CNT_W'(val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random beat: a quarter are table writes, the rest queries. Most queries aim
  // at a start or an end of some slot, shifted by a random number of loops.
  task automatic send_random_item();
    int                p;
    int                pick;
    int                tgt;
    int                slot;
    longint            k;
    logic [STEP_W-1:0] s;
    p = loop_steps();
    if ($urandom_range(0, 3) == 0) begin
      send_write(SLOT_W'($urandom()),
                 $urandom_range(0, 1) ? START_W'($urandom_range(0, p - 1)) : START_W'($urandom()),
                 ($urandom_range(0, 2) != 0) ? LEN_W'($urandom_range(0, p)) : LEN_W'($urandom()));
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        s = $urandom();
      end else if (pick == 2) begin
        s = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF) ^ STEP_W'($urandom_range(0, 7));
      end else begin
        slot = $urandom_range(0, DEF_MAX_EVENTS - 1);
        tgt  = int'(slot_start[slot]);
        if ($urandom_range(0, 1)) tgt += int'(slot_dur[slot]);
        tgt  = tgt + int'($urandom_range(0, 2)) - 1;
        k    = longint'($urandom_range(0, 2097152)) - 64'sd1048576;
        s    = STEP_W'(k * p + tgt);
      end
      send_query(s);
    end
  endtask

  // After reset no slot takes part yet, so queries only exercise the wrap at length 16.
  task automatic test_reset_defaults();
    send_query(32'hFFFF_FFFF);
    send_query(32'd16);
  endtask

  // Fill every slot before any query can read one; cover the field extremes.
  task automatic test_table_fill();
    send_write(SLOT_W'(0), 8'd0, 9'd0);
    send_write(SLOT_W'(1), 8'd255, 9'd511);
    send_write(SLOT_W'(2), 8'd3, 9'd256);
    send_write(SLOT_W'(3), 8'd15, 9'd1);
    for (int i = 4; i < DEF_MAX_EVENTS; i++)
      send_write(SLOT_W'(i), START_W'(i * 7), LEN_W'(i * 3));
  endtask

  task automatic test_directed_matches();
    write_reg(CFG_EVENTS_IN_USE, CFG_DATA_W'(16));
    // Zero-length event starts and ends at step zero but is never active.
    send_query(32'd0);
    send_query(32'd3);
    send_query(32'h8000_0000);
    send_query(32'h7FFF_FFFF);
    send_query(32'hFFFF_FFF1);
    // Zero pattern length acts as a one-step loop.
    write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(0));
    send_query(32'd12345);
    // Oversized pattern length saturates to the full table of steps.
    write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(511));
    send_query(32'hFFFF_FFFF);
    // Oversized event count saturates to all slots.
    write_reg(CFG_EVENTS_IN_USE, CFG_DATA_W'(31));
    send_query(32'hFFFF_FFFE);
  endtask

  // Full-rate burst with no idling, a pause until everything drains, then more.
  task automatic test_burst_and_pause();
    write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(16));
    write_reg(CFG_EVENTS_IN_USE, CFG_DATA_W'(16));
    no_idle = 1'b1;
    repeat (40) send_random_item();
    drain();
    repeat (20) send_random_item();
    no_idle = 1'b0;
  endtask

  // Random traffic under a series of register settings, extremes first.
  task automatic test_random_phases();
    int plen_v;
    int cnt_v;
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: plen_v = 1;
        1: plen_v = 256;
        2: plen_v = 0;
        3: plen_v = 511;
        default: plen_v = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 511)
                                                      : $urandom_range(2, 24);
      endcase
      case (ph)
        0: cnt_v = 16;
        1: cnt_v = 0;
        2: cnt_v = 31;
        3: cnt_v = 17;
        default: cnt_v = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 31);
      endcase
      write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(plen_v));
      write_reg(CFG_EVENTS_IN_USE, CFG_DATA_W'(cnt_v));
      // Every fourth phase runs back to back on both sides.
      no_idle = (ph % 4 == 3);
      repeat (70) send_random_item();
      no_idle = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result side: stall for a random stretch, then take one beat and score it
  // against the oldest prediction.
  initial begin : result_checker
    match_t want;
    int     hold;
    forever begin
      hold = draw_wait();
      @(negedge clk_i);
      out_stall_i <= (hold != 0);
      if (hold != 0) begin
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (predicted_matches.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no prediction pending, wrapped_step %0d",
                 $time, wrapped_step_o);
      end else begin
        want = predicted_matches.pop_front();
        check_field("wrapped_step", want.wstep, wrapped_step_o);
        check_field("start_found", want.start_hit, start_found_o);
        check_field("start_slot", want.start_slot, start_slot_o);
        check_field("active_found", want.active_hit, active_found_o);
        check_field("active_slot", want.active_slot, active_slot_o);
        check_field("end_found", want.end_hit, end_found_o);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_table_fill();
    test_directed_matches();
    test_burst_and_pause();
    test_random_phases();
    drain();
    // Give any stray result beat time to show up.
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && predicted_matches.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog that fails the run if it does not finish.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> pattern_event_matcher.f
+incdir+rtl
rtl/pem_pkg.sv
rtl/pem_front.sv
rtl/pem_back.sv
rtl/pattern_event_matcher.sv
dv/tb_pattern_event_matcher.sv
